// ===== sv/jtfe_pkg.sv =====
// Package for the tag field extractor: types, character codes and match helpers.
`default_nettype none

package jtfe_pkg;

  // Design defaults
  localparam int unsigned TAG_CAPACITY_DEF = 32;
  localparam int unsigned STORE_DEPTH_MAX  = 32;
  localparam logic [5:0]  CAP_RESET        = 6'd32;

  // Key length in bytes, both quotes included
  localparam logic [3:0]  KEY_LEN = 4'd10;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SEEK,
    PH_PRE_COLON,
    PH_POST_COLON,
    PH_IN_STRING,
    PH_DONE
  } phase_t;

  // Top control: scanning input or streaming a stored run out
  typedef enum logic {
    CTL_SCAN,
    CTL_EMIT
  } ctl_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_FOUND,
    STAT_KEY_MISSING,
    STAT_BAD_SEP,
    STAT_NULL_VALUE,
    STAT_NOT_STRING,
    STAT_BAD_CHAR,
    STAT_EMPTY
  } status_t;

  // Key character at a match position
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CH_QUOTE;
      4'd1:    c = 8'h74;  // t
      4'd2:    c = 8'h61;  // a
      4'd3:    c = 8'h67;  // g
      4'd4:    c = CH_UNDER;
      4'd5:    c = 8'h6E;  // n
      4'd6:    c = 8'h61;  // a
      4'd7:    c = 8'h6D;  // m
      4'd8:    c = 8'h65;  // e
      4'd9:    c = CH_QUOTE;
      default: c = 8'h00;  // never matches a key byte past the end
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic char_allowed(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) ||
           (c == CH_DOT) || (c == CH_UNDER) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // Escapes that name control codes or unicode are rejected
  function automatic logic bad_escape(input logic [7:0] b);
    return (b == CH_LOW_N) || (b == CH_LOW_T) || (b == CH_LOW_R) ||
           (b == CH_LOW_B) || (b == CH_LOW_F) || (b == CH_LOW_U);
  endfunction

endpackage

`default_nettype wire

// ===== sv/json_tag_field_extractor.sv =====
// Top level: scans a body for the quoted key and streams the decoded tag out.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------------
//   in      | sink      | in_valid / in_stall  | body_byte, last_byte
//   out     | source    | out_valid / out_stall| status, tag_char, char_index, tag_length,
//           |           |                      | last_result
//   cfg     | sink      | cfg_write            | cfg_data (tag_capacity)
//
// One body byte is taken per cycle while scanning, unless a stall on out holds the output
// register. A byte that ends the string or the body with a found tag starts streaming: a
// registered store read first, then one word per cycle while out is not stalled; input
// stalls until the last tag character is loaded into the output register.
// A status word goes straight into the output register at the edge that takes its byte.
// Reset (rst, synchronous) returns the parser to seeking the key; the store needs no clear.
// A stall on out holds the output word and stalls in while the output register is full.
`default_nettype none

module json_tag_field_extractor #(
  parameter int unsigned TAG_CAPACITY = jtfe_pkg::TAG_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] body_byte,
  input  logic       last_byte,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] tag_char,
  output logic [4:0] char_index,
  output logic [4:0] tag_length,
  output logic       last_result,
  // configuration
  input  logic       cfg_write,
  input  logic [5:0] cfg_data
);
  import jtfe_pkg::*;

  localparam int unsigned StoreDepth =
    (TAG_CAPACITY < STORE_DEPTH_MAX) ? TAG_CAPACITY : STORE_DEPTH_MAX;
  localparam int unsigned AW = $clog2(StoreDepth);
  localparam logic [5:0]  CapMax = 6'(StoreDepth);

  // Registers
  ctl_t        ctl, ctl_next;
  phase_t      phase, phase_next;
  logic [3:0]  kp, kp_next;
  logic        esc, esc_next;
  logic [4:0]  count, count_next;
  logic [5:0]  cap;
  logic [4:0]  run_len;
  logic [4:0]  emit_idx;
  logic [4:0]  rd_idx;
  logic        data_ok;
  logic [7:0]  rd_data;
  logic [7:0]  tag_mem [StoreDepth];

  // Scan results
  logic        wr_en;
  logic        res_stat;
  logic        res_run;
  status_t     res_code;
  logic [4:0]  run_cnt;
  logic        take;
  logic [3:0]  kp_sum;
  logic [5:0]  lim;
  logic [4:0]  keep;

  // Handshake and streaming control
  logic        in_accept;
  logic        out_free;
  logic        em_load;
  logic        em_issue;
  logic        em_last;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (ctl == CTL_EMIT) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  // Stored characters allowed: clamp capacity to 1..StoreDepth, minus one
  always_comb begin
    lim = (cap == 6'd0) ? 6'd1 : cap;
    if (lim > CapMax) begin
      lim = CapMax;
    end
    keep = 5'(lim - 6'd1);
  end

  // Byte parser: next phase, store write and result kind for the current byte
  always_comb begin
    phase_next = phase;
    kp_next    = kp;
    esc_next   = esc;
    count_next = count;
    wr_en      = 1'b0;
    res_stat   = 1'b0;
    res_run    = 1'b0;
    res_code   = STAT_FOUND;
    take       = 1'b0;
    kp_sum     = 4'd0;

    unique case (phase)
      PH_SEEK: begin
        if (key_char(kp) == body_byte) begin
          kp_sum = kp + 4'd1;
        end else begin
          kp_sum = (body_byte == CH_QUOTE) ? 4'd1 : 4'd0;
        end
        if (kp_sum == KEY_LEN) begin
          kp_next    = 4'd0;
          phase_next = PH_PRE_COLON;
        end else begin
          kp_next = kp_sum;
        end
      end
      PH_PRE_COLON: begin
        if (body_byte == CH_COLON) begin
          phase_next = PH_POST_COLON;
        end else if (!is_ws(body_byte)) begin
          res_stat = 1'b1;
          res_code = STAT_BAD_SEP;
        end
      end
      PH_POST_COLON: begin
        if (body_byte == CH_QUOTE) begin
          phase_next = PH_IN_STRING;
          count_next = 5'd0;
          esc_next   = 1'b0;
        end else if (body_byte == CH_LOW_N) begin
          res_stat = 1'b1;
          res_code = STAT_NULL_VALUE;
        end else if (!is_ws(body_byte)) begin
          res_stat = 1'b1;
          res_code = STAT_NOT_STRING;
        end
      end
      PH_IN_STRING: begin
        if (esc) begin
          esc_next = 1'b0;
          if (bad_escape(body_byte)) begin
            res_stat = 1'b1;
            res_code = STAT_BAD_CHAR;
          end else begin
            take = 1'b1;
          end
        end else if (body_byte == CH_QUOTE) begin
          res_run = 1'b1;
        end else if (body_byte == CH_BSLASH) begin
          esc_next = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // Character check and store; extra characters are dropped
    if (take) begin
      if (!char_allowed(body_byte)) begin
        res_stat = 1'b1;
        res_code = STAT_BAD_CHAR;
      end else if (count < keep) begin
        wr_en      = 1'b1;
        count_next = count + 5'd1;
      end
    end

    if (res_stat || res_run) begin
      phase_next = PH_DONE;
    end
    run_cnt = count_next;

    // End of body: report by the phase reached, then rearm
    if (last_byte) begin
      if (!res_stat && !res_run) begin
        unique case (phase_next)
          PH_SEEK: begin
            res_stat = 1'b1;
            res_code = STAT_KEY_MISSING;
          end
          PH_PRE_COLON: begin
            res_stat = 1'b1;
            res_code = STAT_BAD_SEP;
          end
          PH_POST_COLON: begin
            res_stat = 1'b1;
            res_code = STAT_NOT_STRING;
          end
          PH_IN_STRING: begin
            if (esc_next) begin
              res_stat = 1'b1;
              res_code = STAT_BAD_CHAR;
            end else begin
              res_run = 1'b1;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
      phase_next = PH_SEEK;
      kp_next    = 4'd0;
      esc_next   = 1'b0;
      count_next = 5'd0;
    end

    // A run with nothing stored is reported as empty
    if (res_run && run_cnt == 5'd0) begin
      res_run  = 1'b0;
      res_stat = 1'b1;
      res_code = STAT_EMPTY;
    end
  end

  // Streaming: issue a read while the read register is free or being drained
  assign em_load  = (ctl == CTL_EMIT) && data_ok && out_free;
  assign em_issue = (ctl == CTL_EMIT) && (emit_idx != run_len) && (!data_ok || out_free);
  assign em_last  = (5'(rd_idx + 5'd1) == run_len);

  // Control state
  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_SCAN: begin
        if (in_accept && res_run) begin
          ctl_next = CTL_EMIT;
        end
      end
      CTL_EMIT: begin
        if (em_load && em_last) begin
          ctl_next = CTL_SCAN;
        end
      end
      default: ctl_next = CTL_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= CTL_SCAN;
    end else begin
      ctl <= ctl_next;
    end
  end

  // Parser state and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK;
      kp    <= 4'd0;
      esc   <= 1'b0;
      count <= 5'd0;
      cap   <= CAP_RESET;
    end else begin
      if (cfg_write) begin
        cap <= cfg_data;
      end
      if (in_accept) begin
        phase <= phase_next;
        kp    <= kp_next;
        esc   <= esc_next;
        count <= count_next;
      end
    end
  end

  // Run bookkeeping
  always_ff @(posedge clk) begin
    if (in_accept && res_run) begin
      run_len  <= run_cnt;
      emit_idx <= 5'd0;
    end else if (em_issue) begin
      emit_idx <= emit_idx + 5'd1;
    end
    if (em_issue) begin
      rd_idx <= emit_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_ok <= 1'b0;
    end else if (em_issue) begin
      data_ok <= 1'b1;
    end else if (em_load) begin
      data_ok <= 1'b0;
    end
  end

  // Tag store: write while scanning, registered read while streaming
  always_ff @(posedge clk) begin
    if (in_accept && wr_en) begin
      tag_mem[count[AW-1:0]] <= body_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (em_issue) begin
      rd_data <= tag_mem[emit_idx[AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_accept && res_stat) || em_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_stat) begin
      status      <= res_code;
      tag_char    <= 8'h00;
      char_index  <= 5'd0;
      tag_length  <= 5'd0;
      last_result <= 1'b1;
    end else if (em_load) begin
      status      <= STAT_FOUND;
      tag_char    <= rd_data;
      char_index  <= rd_idx;
      tag_length  <= run_len;
      last_result <= em_last;
    end
  end

  // Checks
  a_status_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_FOUND |-> last_result && tag_char == 8'h00)
    else $error("status word not marked last or carries a character");

  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    ctl == CTL_EMIT |-> (phase == PH_DONE || phase == PH_SEEK))
    else $error("streaming while parser is mid-string");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |=>
      out_valid && char_index == 5'($past(char_index) + 5'd1))
    else $error("gap or skipped index in tag run");

  a_read_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    data_ok |-> ctl == CTL_EMIT)
    else $error("store read data pending outside streaming");

endmodule

`default_nettype wire
